// ----- rtl/core/scf_pkg.sv -----
// Shared types, constants and helpers for the serial command framer.
package scf_pkg;

  localparam int MAX_PARAMS_DEF = 32;

  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 2;
  localparam int IDX_W   = 5;
  localparam int NEED_W  = 6;
  localparam int TICK_W  = 8;

  localparam logic [BYTE_W-1:0] CMD_SET_ROW = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_BRIGHT  = 8'h21;
  localparam logic [BYTE_W-1:0] CMD_BLINK   = 8'h22;
  localparam logic [BYTE_W-1:0] CMD_GRAM    = 8'h23;

  localparam logic [CODE_W-1:0] CODE_SET_ROW = 2'd0;
  localparam logic [CODE_W-1:0] CODE_BRIGHT  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_BLINK   = 2'd2;
  localparam logic [CODE_W-1:0] CODE_GRAM    = 2'd3;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 8'd6;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic EV_PARAM   = 1'b0;
  localparam logic EV_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic take;   // input transfer this cycle
    logic read;   // fetch next stored parameter into the output register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic tout_emit;   // current input is a tick that abandons a partial frame
    logic frame_done;  // current input is the byte that completes a frame
    logic out_last;    // output register holds the last result of its run
  } dp_sts_t;

  function automatic logic cmd_known(input logic [BYTE_W-1:0] b);
    return (b == CMD_SET_ROW) || (b == CMD_BRIGHT) || (b == CMD_BLINK) ||
           (b == CMD_GRAM);
  endfunction

  function automatic logic [NEED_W-1:0] need_of(input logic [CODE_W-1:0] code);
    logic [NEED_W-1:0] n;
    case (code)
      CODE_SET_ROW: n = 6'd2;
      CODE_BRIGHT:  n = 6'd1;
      CODE_BLINK:   n = 6'd1;
      CODE_GRAM:    n = 6'd32;
      default:      n = 6'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/core/scf_ctrl.sv -----
// Sequencer for input transfers, parameter drain and result hand-off.
module scf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  scf_pkg::dp_sts_t  sts,
  output scf_pkg::ctrl_cmd_t cmd
);
  import scf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.tout_emit) begin
            state_next = ST_SHOW;
          end else if (sts.frame_done) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          state_next = sts.out_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/scf_datapath.sv -----
// Frame state, parameter store, timeout counter and output register.
module scf_datapath #(
  parameter int MAX_PARAMS = scf_pkg::MAX_PARAMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         kind,
  input  logic [scf_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                         cfg_valid,
  input  logic [scf_pkg::TICK_W-1:0]   cfg_data,
  input  scf_pkg::ctrl_cmd_t           cmd,
  output scf_pkg::dp_sts_t             sts,
  output logic                         event_res,
  output logic [scf_pkg::CODE_W-1:0]   command,
  output logic [scf_pkg::IDX_W-1:0]    param_index,
  output logic [scf_pkg::BYTE_W-1:0]   param_value,
  output logic                         last
);
  import scf_pkg::*;

  localparam int AW    = $clog2(MAX_PARAMS);
  localparam int CNT_W = $clog2(MAX_PARAMS + 1);

  logic [TICK_W-1:0] timeout_ticks;
  logic              awaiting;
  logic              known;
  logic [CODE_W-1:0] code;
  logic [CNT_W-1:0]  count;
  logic [TICK_W-1:0] idle_ticks;
  logic [AW-1:0]     rd_idx;
  logic [BYTE_W-1:0] store [MAX_PARAMS];

  logic [TICK_W:0]   idle_inc;
  logic              fire;
  logic              room;
  logic [NEED_W-1:0] need;
  logic              store_wr;

  assign idle_inc = {1'b0, idle_ticks} + {{TICK_W{1'b0}}, 1'b1};
  assign fire     = (kind == KIND_TICK) && (idle_inc >= {1'b0, timeout_ticks});
  assign need     = need_of(code);
  assign room     = 32'(count) < MAX_PARAMS;
  assign store_wr = cmd.take && (kind == KIND_BYTE) && !awaiting && known && room;

  assign sts.tout_emit  = fire && !awaiting;
  assign sts.frame_done = (kind == KIND_BYTE) && !awaiting && known && room &&
                          (32'(count) + 32'd1 == 32'(need));
  assign sts.out_last   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      awaiting      <= 1'b1;
      known         <= 1'b0;
      code          <= CODE_SET_ROW;
      count         <= '0;
      idle_ticks    <= '0;
      rd_idx        <= '0;
    end else begin
      if (cfg_valid) begin
        timeout_ticks <= cfg_data;
      end
      if (cmd.read) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (cmd.take) begin
        if (kind == KIND_TICK) begin
          if (fire) begin
            idle_ticks <= '0;
            known      <= 1'b0;
            code       <= CODE_SET_ROW;
            count      <= '0;
            awaiting   <= 1'b1;
          end else begin
            idle_ticks <= idle_inc[TICK_W-1:0];
          end
        end else begin
          idle_ticks <= '0;
          if (awaiting) begin
            awaiting <= 1'b0;
            known    <= cmd_known(rx_byte);
            code     <= cmd_known(rx_byte) ? rx_byte[CODE_W-1:0] : CODE_SET_ROW;
            count    <= '0;
          end else if (store_wr) begin
            if (sts.frame_done) begin
              awaiting <= 1'b1;
              count    <= '0;
              rd_idx   <= '0;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
      end
    end
  end

  // Store and output payload: no reset needed.
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store[count[AW-1:0]] <= rx_byte;
    end
    if (cmd.take && sts.tout_emit) begin
      event_res   <= EV_TIMEOUT;
      command     <= code;
      param_index <= '0;
      param_value <= '0;
      last        <= 1'b1;
    end else if (cmd.read) begin
      event_res   <= EV_PARAM;
      command     <= code;
      param_index <= IDX_W'(rd_idx);
      param_value <= store[rd_idx];
      last        <= (32'(rd_idx) + 32'd1 == 32'(need));
    end
  end

endmodule

// ----- rtl/core/serial_command_framer.sv -----
// Top level of the serial command framer: controller plus datapath.
//
//  Channel | Signals                                   | Direction | Moves
//  --------+-------------------------------------------+-----------+---------------------------
//  in      | in_valid, in_ready, kind, rx_byte         | input     | one byte or timer tick
//  out     | out_valid, out_ready, event_res, command, | output    | one parameter or timeout
//          | param_index, param_value, last            |           | result
//  cfg     | cfg_valid, cfg_ready, cfg_data            | input     | timeout_ticks write
//
// An input transfer that produces no result leaves the block idle, so in_ready
// stays high. A completing byte starts a drain through the parameter store's
// single registered read port: each result is read, then shown. A timeout
// result is loaded on the tick's transfer and shown the next cycle. in_ready
// stays low while any result of the current item is pending; out_ready low
// holds the output register. Synchronous active-high reset restores
// timeout_ticks to 6 and the frame state to awaiting a command; the store
// itself is not cleared. cfg_ready is always high.
module serial_command_framer #(
  parameter int MAX_PARAMS = scf_pkg::MAX_PARAMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [scf_pkg::BYTE_W-1:0]   rx_byte,
  // results
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         event_res,
  output logic [scf_pkg::CODE_W-1:0]   command,
  output logic [scf_pkg::IDX_W-1:0]    param_index,
  output logic [scf_pkg::BYTE_W-1:0]   param_value,
  output logic                         last,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [scf_pkg::TICK_W-1:0]   cfg_data
);
  import scf_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Config writes land whenever offered; the user must issue them only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  scf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scf_datapath #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .kind        (kind),
    .rx_byte     (rx_byte),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .event_res   (event_res),
    .command     (command),
    .param_index (param_index),
    .param_value (param_value),
    .last        (last)
  );

  // Input and output sides never overlap: one item at a time.
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  // The last result of a run returns the block to taking input.
  assert property (@(posedge clk) disable iff (rst)
      out_valid && out_ready && last |=> in_ready)
    else $error("not idle after final result transfer");

  // A timeout result is always a single, zero-payload result.
  assert property (@(posedge clk) disable iff (rst)
      out_valid && (event_res == EV_TIMEOUT) |->
        last && (param_index == '0) && (param_value == '0))
    else $error("malformed timeout result");

  // A tick never leads straight into a parameter drain.
  assert property (@(posedge clk) disable iff (rst)
      in_valid && in_ready && (kind == KIND_TICK) |=> !out_valid || event_res == EV_TIMEOUT)
    else $error("tick produced a parameter result");

endmodule
